// ===== sv/gsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsm_pkg: shared types and codes for the gesture sequence matcher
// Field widths, request kinds, element classes, register indexes, reset values, rest pose and FSM types.
// ----------------------------------------------------------------------------
package gsm_pkg;

    // payload field widths
    localparam int KIND_W  = 2;
    localparam int MODE_W  = 3;
    localparam int SLOT_W  = 3;
    localparam int POS_W   = 3;
    localparam int POSE_W  = 3;
    localparam int CLASS_W = 2;
    localparam int CMD_W   = 16;
    localparam int DELTA_W = 16;
    localparam int MASK_W  = 8;
    localparam int HOLD_W  = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 32;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POSE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

    // element length classes
    localparam logic [CLASS_W-1:0] CLS_TAP       = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_HOLD      = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_IMMEDIATE = 2'd2;
    // spare class code, never advances
    localparam logic [CLASS_W-1:0] CLS_SPARE     = 2'd3;

    // configuration register indexes
    localparam logic CFG_HOLD_TIME = 1'b0;
    localparam logic CFG_MAX_GAP   = 1'b1;

    // register reset values
    localparam logic [HOLD_W-1:0] HOLD_TIME_RST = 16'd500;
    localparam logic [TIME_W-1:0] MAX_GAP_RST   = 32'd2000;

    // rest pose
    localparam logic [POSE_W-1:0] POSE_REST = 3'd0;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLEAR = 5'b00010,
        ST_ISSUE = 5'b00100,
        ST_EVAL  = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_ADV   = 2'd1,
        OP_TICK  = 2'd2
    } t_loop;

endpackage

// ===== sv/gsm_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsm_req_if: request channel of the gesture sequence matcher
// Valid/ready handshake with the table load, pose, tick and clear fields.
// ----------------------------------------------------------------------------
interface gsm_req_if import gsm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [MODE_W-1:0]    mode;
    logic [SLOT_W-1:0]    slot;
    logic [POS_W-1:0]     position;
    logic [POSE_W-1:0]    pose;
    logic [CLASS_W-1:0]   hold_class;
    logic                 last_element;
    logic [CMD_W-1:0]     command;
    logic [DELTA_W-1:0]   delta;

    modport source (
        output valid, kind, mode, slot, position, pose, hold_class,
               last_element, command, delta,
        input  ready
    );
    modport sink (
        input  valid, kind, mode, slot, position, pose, hold_class,
               last_element, command, delta,
        output ready
    );
endinterface

// ----------------------------------------------------------------------------
// gsm_rsp_if: response channel of the gesture sequence matcher
// Valid/ready handshake with the completion, status and candidate mask fields.
// ----------------------------------------------------------------------------
interface gsm_rsp_if import gsm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 response_valid;
    logic [CMD_W-1:0]     response_command;
    logic                 status;
    logic [MASK_W-1:0]    active_mask;

    modport source (
        output valid, response_valid, response_command, status, active_mask,
        input  ready
    );
    modport sink (
        input  valid, response_valid, response_command, status, active_mask,
        output ready
    );
endinterface

// ===== sv/gsm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsm_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/gesture_sequence_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesture_sequence_matcher: pose sequence matcher over a per-mode table
// Timing: loads pass straight to the DONE state; pose events and ticks that walk the table
//   visit each slot in turn, an ISSUE state (table RAM reads in flight) then an EVAL state,
//   ending at a match; a clear sweeps all MODE_COUNT*SLOTS_PER_MODE entries, then DONE.
// Throughput: one request at a time, next request taken once the result is registered.
// Reset: synchronous; a clearing pass over all MODE_COUNT*SLOTS_PER_MODE entries empties the
//   sequence table before the first request is taken.
// ----------------------------------------------------------------------------
module gesture_sequence_matcher import gsm_pkg::*; #(
    parameter int MODE_COUNT     = 8,
    parameter int SLOTS_PER_MODE = 8,
    parameter int MAX_SEQ_LEN    = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gsm_req_if.sink           i_req,
    gsm_rsp_if.source         o_rsp,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);
    localparam int SEQ_TOTAL  = MODE_COUNT * SLOTS_PER_MODE;
    localparam int ELEM_TOTAL = SEQ_TOTAL * MAX_SEQ_LEN;
    localparam int SAW = (SEQ_TOTAL > 1) ? $clog2(SEQ_TOTAL) : 1;
    localparam int EAW = (ELEM_TOTAL > 1) ? $clog2(ELEM_TOTAL) : 1;
    localparam int SW  = (SLOTS_PER_MODE > 1) ? $clog2(SLOTS_PER_MODE) : 1;
    localparam int LW  = $clog2(MAX_SEQ_LEN + 1);
    localparam int SEQ_DW  = LW + CMD_W;
    localparam int ELEM_DW = POSE_W + CLASS_W;

    // control and context registers
    t_state                     r_state, n_state;
    t_loop                      r_op, n_op;
    logic                       r_clr_item, n_clr_item;
    logic [SAW-1:0]             r_clr, n_clr;
    logic [SW-1:0]              r_slot, n_slot;
    logic [MODE_W-1:0]          r_last_mode, n_last_mode;
    logic [POSE_W-1:0]          r_last_pose, n_last_pose;
    logic [POSE_W-1:0]          r_pose, n_pose;
    logic [HOLD_W-1:0]          r_hc, n_hc;
    logic [TIME_W-1:0]          r_tick, n_tick;
    logic [TIME_W-1:0]          r_base, n_base;
    logic [HOLD_W-1:0]          r_hold_time, n_hold_time;
    logic [TIME_W-1:0]          r_max_gap, n_max_gap;
    logic [SLOTS_PER_MODE-1:0]  r_active, n_active;
    logic [LW-1:0]              r_prog [SLOTS_PER_MODE];
    logic [LW-1:0]              n_prog [SLOTS_PER_MODE];
    logic                       r_res_valid, n_res_valid;
    logic [CMD_W-1:0]           r_res_cmd, n_res_cmd;
    logic                       r_res_status, n_res_status;
    logic                       r_out_valid, n_out_valid;
    logic                       r_out_rv, n_out_rv;
    logic [CMD_W-1:0]           r_out_cmd, n_out_cmd;
    logic                       r_out_status, n_out_status;
    logic [MASK_W-1:0]          r_out_mask, n_out_mask;

    // memory ports
    logic                 w_seq_we;
    logic [SAW-1:0]       w_seq_waddr, w_seq_raddr;
    logic [SEQ_DW-1:0]    w_seq_wdata, w_seq_rdata;
    logic                 w_elem_we;
    logic [EAW-1:0]       w_elem_waddr, w_elem_raddr;
    logic [ELEM_DW-1:0]   w_elem_wdata, w_elem_rdata;

    // evaluation helpers
    logic                 w_accept;
    logic                 w_load_ok;
    logic                 w_mode_ok;
    logic [LW-1:0]        w_len;
    logic [CMD_W-1:0]     w_cmd;
    logic [POSE_W-1:0]    w_epose;
    logic [CLASS_W-1:0]   w_ecls;
    logic [LW-1:0]        w_prog;
    logic [LW-1:0]        w_prog_inc;
    logic                 w_in_range;
    logic                 w_last_slot;
    logic [TIME_W-1:0]    w_gap;
    logic [SLOTS_PER_MODE+MASK_W-1:0] w_mask_pad;

    gsm_ram #(.WIDTH(SEQ_DW), .DEPTH(SEQ_TOTAL)) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (w_seq_we),
        .i_waddr (w_seq_waddr),
        .i_wdata (w_seq_wdata),
        .i_raddr (w_seq_raddr),
        .o_rdata (w_seq_rdata)
    );

    gsm_ram #(.WIDTH(ELEM_DW), .DEPTH(ELEM_TOTAL)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (w_elem_we),
        .i_waddr (w_elem_waddr),
        .i_wdata (w_elem_wdata),
        .i_raddr (w_elem_raddr),
        .o_rdata (w_elem_rdata)
    );

    // request handshake
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && (r_state == ST_IDLE);

    // table load address and range
    assign w_load_ok = (32'(i_req.mode) < MODE_COUNT) && (32'(i_req.slot) < SLOTS_PER_MODE)
                       && (32'(i_req.position) < MAX_SEQ_LEN);

    // table writes: loads, or the clearing sweep
    always_comb begin
        w_elem_we    = w_accept && (i_req.kind == KIND_LOAD) && w_load_ok;
        w_elem_waddr = EAW'((32'(i_req.mode) * SLOTS_PER_MODE + 32'(i_req.slot)) * MAX_SEQ_LEN
                            + 32'(i_req.position));
        w_elem_wdata = {i_req.pose, i_req.hold_class};
        if (r_state == ST_CLEAR) begin
            w_seq_we    = 1'b1;
            w_seq_waddr = r_clr;
            w_seq_wdata = '0;
        end else begin
            w_seq_we    = w_elem_we && i_req.last_element;
            w_seq_waddr = SAW'(32'(i_req.mode) * SLOTS_PER_MODE + 32'(i_req.slot));
            w_seq_wdata = {LW'(32'(i_req.position) + 1), i_req.command};
        end
    end

    // table reads for the current slot
    assign w_seq_raddr  = SAW'(32'(r_last_mode) * SLOTS_PER_MODE + 32'(r_slot));
    assign w_prog       = r_prog[r_slot];
    assign w_elem_raddr = EAW'((32'(r_last_mode) * SLOTS_PER_MODE + 32'(r_slot)) * MAX_SEQ_LEN
                               + ((r_op == OP_START) ? 32'd0 : 32'(w_prog)));

    // slot evaluation terms
    assign w_mode_ok   = (32'(r_last_mode) < MODE_COUNT);
    assign w_len       = w_mode_ok ? w_seq_rdata[SEQ_DW-1:CMD_W] : '0;
    assign w_cmd       = w_seq_rdata[CMD_W-1:0];
    assign w_epose     = w_elem_rdata[ELEM_DW-1:CLASS_W];
    assign w_ecls      = w_elem_rdata[CLASS_W-1:0];
    assign w_in_range  = (w_prog < w_len);
    assign w_prog_inc  = w_prog + LW'(1);
    assign w_last_slot = (r_slot == SW'(SLOTS_PER_MODE - 1));
    assign w_gap       = r_tick - r_base;
    assign w_mask_pad  = {{MASK_W{1'b0}}, r_active};

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_clr_item   = r_clr_item;
        n_clr        = r_clr;
        n_slot       = r_slot;
        n_last_mode  = r_last_mode;
        n_last_pose  = r_last_pose;
        n_pose       = r_pose;
        n_hc         = r_hc;
        n_tick       = r_tick;
        n_base       = r_base;
        n_hold_time  = r_hold_time;
        n_max_gap    = r_max_gap;
        n_active     = r_active;
        n_prog       = r_prog;
        n_res_valid  = r_res_valid;
        n_res_cmd    = r_res_cmd;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_rv     = r_out_rv;
        n_out_cmd    = r_out_cmd;
        n_out_status = r_out_status;
        n_out_mask   = r_out_mask;

        // configuration writes
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HOLD_TIME: n_hold_time = i_cfg_data[HOLD_W-1:0];
                CFG_MAX_GAP:   n_max_gap   = i_cfg_data;
                default:       ;
            endcase
        end

        // response taken downstream
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_pose       = i_req.pose;
                    n_slot       = '0;
                    n_res_valid  = 1'b0;
                    n_res_cmd    = '0;
                    n_res_status = 1'b0;
                    n_state      = ST_DONE;
                    case (i_req.kind)
                        KIND_LOAD: ;
                        KIND_POSE: begin
                            n_last_pose = i_req.pose;
                            if (|r_active) begin
                                if (i_req.mode != r_last_mode) begin
                                    n_last_mode  = i_req.mode;
                                    n_res_status = 1'b1;
                                    n_active     = '0;
                                    for (int i = 0; i < SLOTS_PER_MODE; i++) n_prog[i] = '0;
                                end else if (w_gap > r_max_gap) begin
                                    n_active = '0;
                                    for (int i = 0; i < SLOTS_PER_MODE; i++) n_prog[i] = '0;
                                end else begin
                                    if (i_req.pose != POSE_REST) n_base = r_tick;
                                    n_op    = OP_ADV;
                                    n_state = ST_ISSUE;
                                end
                            end else begin
                                n_last_mode = i_req.mode;
                                n_op        = OP_START;
                                n_state     = ST_ISSUE;
                            end
                        end
                        KIND_TICK: begin
                            n_tick = r_tick + TIME_W'(i_req.delta);
                            n_hc   = (i_req.delta >= r_hc) ? '0 : r_hc - i_req.delta;
                            if ((r_hc != '0) && (i_req.delta >= r_hc) && (|r_active)) begin
                                n_op    = OP_TICK;
                                n_state = ST_ISSUE;
                            end
                        end
                        KIND_CLEAR: begin
                            n_clr      = '0;
                            n_clr_item = 1'b1;
                            n_active   = '0;
                            for (int i = 0; i < SLOTS_PER_MODE; i++) n_prog[i] = '0;
                            n_state    = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end

            // empty the sequence table one entry a cycle
            ST_CLEAR: begin
                n_clr = r_clr + SAW'(1);
                if (r_clr == SAW'(SEQ_TOTAL - 1)) begin
                    n_state    = r_clr_item ? ST_DONE : ST_IDLE;
                    n_clr_item = 1'b0;
                end
            end

            // table reads in flight
            ST_ISSUE: begin
                n_state = ST_EVAL;
            end

            // evaluate one slot
            ST_EVAL: begin
                n_slot  = r_slot + SW'(1);
                n_state = w_last_slot ? ST_DONE : ST_ISSUE;
                case (r_op)
                    OP_START: begin
                        if ((w_len != '0) && (w_epose == r_pose)) begin
                            n_base = r_tick;
                            if (w_ecls == CLS_IMMEDIATE) begin
                                n_res_valid = 1'b1;
                                n_res_cmd   = w_cmd;
                                n_active    = '0;
                                for (int i = 0; i < SLOTS_PER_MODE; i++) n_prog[i] = '0;
                                n_state     = ST_DONE;
                            end else begin
                                n_active[r_slot] = 1'b1;
                                n_prog[r_slot]   = '0;
                                n_hc             = r_hold_time;
                            end
                        end
                    end
                    OP_ADV: begin
                        if (r_active[r_slot]) begin
                            if (r_pose == POSE_REST) begin
                                if (r_hc != '0) begin
                                    if (w_in_range && (w_ecls == CLS_TAP)) begin
                                        n_prog[r_slot] = w_prog_inc;
                                        if (w_prog_inc == w_len) begin
                                            n_res_valid = 1'b1;
                                            n_res_cmd   = w_cmd;
                                            n_active    = '0;
                                            for (int i = 0; i < SLOTS_PER_MODE; i++) begin
                                                n_prog[i] = '0;
                                            end
                                            n_state     = ST_DONE;
                                        end
                                    end else begin
                                        n_active[r_slot] = 1'b0;
                                        n_prog[r_slot]   = '0;
                                    end
                                end
                            end else if (w_in_range && (w_epose == r_pose)) begin
                                n_hc = r_hold_time;
                            end else begin
                                n_active[r_slot] = 1'b0;
                                n_prog[r_slot]   = '0;
                            end
                        end
                    end
                    OP_TICK: begin
                        if (r_active[r_slot] && w_in_range) begin
                            if (w_ecls == CLS_HOLD) begin
                                n_prog[r_slot] = w_prog_inc;
                                if (w_prog_inc == w_len) begin
                                    n_res_valid = 1'b1;
                                    n_res_cmd   = w_cmd;
                                    n_active    = '0;
                                    for (int i = 0; i < SLOTS_PER_MODE; i++) n_prog[i] = '0;
                                    n_state     = ST_DONE;
                                end
                            end else if (r_last_pose != POSE_REST) begin
                                n_active[r_slot] = 1'b0;
                                n_prog[r_slot]   = '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            // move the result into the output register
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_rv     = r_res_valid;
                    n_out_cmd    = r_res_cmd;
                    n_out_status = r_res_status;
                    n_out_mask   = w_mask_pad[MASK_W-1:0];
                    n_state      = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_op        <= OP_START;
            r_clr_item  <= 1'b0;
            r_clr       <= '0;
            r_slot      <= '0;
            r_last_mode <= '0;
            r_last_pose <= POSE_REST;
            r_hc        <= HOLD_TIME_RST;
            r_tick      <= '0;
            r_base      <= '0;
            r_hold_time <= HOLD_TIME_RST;
            r_max_gap   <= MAX_GAP_RST;
            r_active    <= '0;
            for (int i = 0; i < SLOTS_PER_MODE; i++) r_prog[i] <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_clr_item  <= n_clr_item;
            r_clr       <= n_clr;
            r_slot      <= n_slot;
            r_last_mode <= n_last_mode;
            r_last_pose <= n_last_pose;
            r_hc        <= n_hc;
            r_tick      <= n_tick;
            r_base      <= n_base;
            r_hold_time <= n_hold_time;
            r_max_gap   <= n_max_gap;
            r_active    <= n_active;
            r_prog      <= n_prog;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pose       <= n_pose;
        r_res_valid  <= n_res_valid;
        r_res_cmd    <= n_res_cmd;
        r_res_status <= n_res_status;
        r_out_rv     <= n_out_rv;
        r_out_cmd    <= n_out_cmd;
        r_out_status <= n_out_status;
        r_out_mask   <= n_out_mask;
    end

    // response channel
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.response_valid   = r_out_rv;
    assign o_rsp.response_command = r_out_cmd;
    assign o_rsp.status           = r_out_status;
    assign o_rsp.active_mask      = r_out_mask;
endmodule
